// ===== hdl/bpa_pkg.sv =====
// Shared types and constants of the buddy page allocator.
package bpa_pkg;

    localparam int PAGE_COUNT      = 256;
    localparam int MAX_ORDER       = 8;
    localparam int PAGE_BYTES_LOG2 = 12;

    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int LINK_W   = PAGE_W + 1;
    localparam int ORD_W    = 4;
    localparam int NUM_ORD  = MAX_ORDER + 1;
    localparam int BYTES_W  = 32;
    localparam int PAGES_W  = BYTES_W + 1 - PAGE_BYTES_LOG2;
    localparam int PM_W     = ORD_W + 1;

    localparam logic [LINK_W-1:0] LINK_NIL   = LINK_W'(PAGE_COUNT);
    localparam logic [ORD_W-1:0]  ORD_MAX    = ORD_W'(MAX_ORDER);
    localparam logic [ORD_W-1:0]  ORDER_NONE = ORD_W'(MAX_ORDER + 1);

    // Result status codes.
    localparam logic [2:0] ST_ALLOC   = 3'd0;
    localparam logic [2:0] ST_FREED   = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_LARGE   = 3'd3;
    localparam logic [2:0] ST_NOBLOCK = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;
    localparam logic [2:0] ST_FREE    = 3'd6;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [ORD_W-1:0]  ord_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_A_TAKE,
        OP_PUSH,
        OP_LINK,
        OP_A_UNLINK,
        OP_F_READ,
        OP_F_CLAIM,
        OP_F_BREAD,
        OP_F_UNLINK,
        OP_F_MERGE,
        OP_DONE
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_SPLIT,
        S_LINK,
        S_F_CHK,
        S_F_LOOK,
        S_F_TEST,
        S_F_MERGE,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;
    } bpa_cmd_t;

    typedef struct packed {
        logic func;
        logic zero;
        logic too_large;
        logic found;
        logic range_err;
        logic split_done;
        logic used;
        logic ord_top;
        logic buddy_ok;
        logic out_busy;
    } bpa_stat_t;

endpackage

// ===== hdl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: controller plus datapath.
//
// The block manages a pool of 256 pages of 4 KiB with buddy free lists of
// orders 0 to 8. A request transfer on the input channel (in_valid, in_stall)
// carries func: 0 allocates request_bytes, 1 frees the block at free_page.
// Every request gives exactly one result transfer on the output channel
// (out_valid, out_stall) with status, block_page and block_order.
// One request is worked at a time; in_stall is high from the cycle after a
// transfer until the result has been loaded into the output register.
// The walk over the list memories takes one step per cycle: an allocation
// walks down its split levels and a free up its merge levels, at most to
// order 8, while a zero, oversized, unavailable or out-of-range request and a
// free of a page that starts no allocated block end without a walk.
// The output register holds a result while out_stall is high, and
// the next request is taken as soon as its result has been loaded there.
// After reset the whole pool is one free block of order 8 at page 0; the page
// table reads its reset value through per-page valid bits, so no clearing
// pass is needed and the block takes a request straight after reset.
module buddy_page_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [bpa_pkg::BYTES_W-1:0] request_bytes,
    input  logic [bpa_pkg::LINK_W-1:0]  free_page,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [bpa_pkg::PAGE_W-1:0]  block_page,
    output logic [bpa_pkg::ORD_W-1:0]   block_order
);
    import bpa_pkg::*;

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    // The controller walks the split or merge levels and issues one
    // datapath command per cycle, and waits to load a result while the last is stalled.
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the page table, the link memories, the list heads
    // and tails, and the output register.
    bpa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .request_bytes (request_bytes),
        .free_page     (free_page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .block_page    (block_page),
        .block_order   (block_order)
    );
endmodule

// ===== hdl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/bpa_ctrl.sv =====
// Controller state machine that sequences allocate and free requests.
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bpa_pkg::bpa_stat_t stat,
    output bpa_pkg::bpa_cmd_t  cmd
);
    import bpa_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (stat.func == FUNC_ALLOC)
                begin
                    if (stat.zero)
                    begin
                        code_next = ST_ZERO;
                    end
                    else if (stat.too_large)
                    begin
                        code_next = ST_LARGE;
                    end
                    else if (!stat.found)
                    begin
                        code_next = ST_NOBLOCK;
                    end
                    else
                    begin
                        state_next = S_A_SPLIT;
                    end
                end
                else if (stat.range_err)
                begin
                    code_next = ST_RANGE;
                end
                else
                begin
                    state_next = S_F_CHK;
                end
            end
            S_A_SPLIT:
            begin
                if (stat.split_done)
                begin
                    state_next = S_DONE;
                    code_next  = ST_ALLOC;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (stat.func == FUNC_FREE)
                begin
                    state_next = S_DONE;
                    code_next  = ST_FREED;
                end
                else
                begin
                    state_next = S_A_SPLIT;
                end
            end
            S_F_CHK:
            begin
                if (!stat.used)
                begin
                    state_next = S_DONE;
                    code_next  = ST_FREE;
                end
                else
                begin
                    state_next = S_F_LOOK;
                end
            end
            S_F_LOOK:
            begin
                state_next = stat.ord_top ? S_LINK : S_F_TEST;
            end
            S_F_TEST:
            begin
                state_next = stat.buddy_ok ? S_F_MERGE : S_LINK;
            end
            S_F_MERGE:
            begin
                state_next = S_F_LOOK;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.code = code_reg;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_DISPATCH:
            begin
                if (stat.func == FUNC_ALLOC)
                begin
                    if (!stat.zero && !stat.too_large && stat.found)
                    begin
                        cmd.op = OP_A_TAKE;
                    end
                end
                else if (!stat.range_err)
                begin
                    cmd.op = OP_F_READ;
                end
            end
            S_A_SPLIT:
            begin
                cmd.op = stat.split_done ? OP_A_UNLINK : OP_PUSH;
            end
            S_LINK:
            begin
                cmd.op = OP_LINK;
            end
            S_F_CHK:
            begin
                if (stat.used)
                begin
                    cmd.op = OP_F_CLAIM;
                end
            end
            S_F_LOOK:
            begin
                cmd.op = stat.ord_top ? OP_PUSH : OP_F_BREAD;
            end
            S_F_TEST:
            begin
                cmd.op = stat.buddy_ok ? OP_F_UNLINK : OP_PUSH;
            end
            S_F_MERGE:
            begin
                cmd.op = OP_F_MERGE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = OP_DONE;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end
endmodule

// ===== hdl/bpa_dp.sv =====
// Datapath: page table, list link memories, free list heads and tails, result register.
module bpa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bpa_pkg::bpa_cmd_t                 cmd,
    output bpa_pkg::bpa_stat_t                stat,
    input  logic                              func,
    input  logic [bpa_pkg::BYTES_W-1:0]       request_bytes,
    input  logic [bpa_pkg::LINK_W-1:0]        free_page,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [bpa_pkg::PAGE_W-1:0]        block_page,
    output logic [bpa_pkg::ORD_W-1:0]         block_order
);
    import bpa_pkg::*;

    // Request registers.
    logic  func_reg, func_next;
    logic  zero_reg, zero_next;
    logic  large_reg, large_next;
    logic  range_reg, range_next;
    ord_t  ord_reg, ord_next;
    ord_t  lvl_reg, lvl_next;
    ord_t  j_reg, j_next;
    page_t pos_reg, pos_next;
    page_t cur_reg, cur_next;
    page_t hi_reg, hi_next;
    page_t np_reg, np_next;
    link_t t_reg, t_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    page_t      block_page_reg, block_page_next;
    ord_t       block_order_reg, block_order_next;

    // Free lists and page table valid bits.
    link_t head_reg [NUM_ORD];
    link_t tail_reg [NUM_ORD];
    logic [PAGE_COUNT-1:0] pm_valid_reg;
    logic  pm_vld_reg, pm_vld_next;
    logic  pm_zero_reg, pm_zero_next;

    logic  head_we, tail_we;
    ord_t  head_idx, tail_idx;
    link_t head_val, tail_val;

    // Memory ports.
    logic              pm_we, pm_re;
    page_t             pm_waddr, pm_raddr;
    logic [PM_W-1:0]   pm_wdata, pm_rdata, pm_q;
    logic              nx_we, nx_re;
    page_t             nx_waddr, nx_raddr;
    link_t             nx_wdata, nx_rdata;
    logic              pv_we, pv_re;
    page_t             pv_waddr, pv_raddr;
    link_t             pv_wdata, pv_rdata;

    // Request decode.
    logic [BYTES_W:0]     bytes_sum;
    logic [PAGES_W-1:0]   pages, pages_m1;
    logic [4:0]           req_ord;

    // Search and helpers.
    logic  found;
    ord_t  found_idx;
    page_t push_page, buddy, lo_page, hi_page;
    ord_t  push_ord;
    link_t t_cur;
    ord_t  claim_ord;
    link_t take_next;

    bpa_ram #(.WIDTH(PM_W), .DEPTH(PAGE_COUNT)) u_page_mem (
        .clk     (clk),
        .wr_en   (pm_we),
        .wr_addr (pm_waddr),
        .wr_data (pm_wdata),
        .rd_en   (pm_re),
        .rd_addr (pm_raddr),
        .rd_data (pm_rdata)
    );

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_next_mem (
        .clk     (clk),
        .wr_en   (nx_we),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata),
        .rd_en   (nx_re),
        .rd_addr (nx_raddr),
        .rd_data (nx_rdata)
    );

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_prev_mem (
        .clk     (clk),
        .wr_en   (pv_we),
        .wr_addr (pv_waddr),
        .wr_data (pv_wdata),
        .rd_en   (pv_re),
        .rd_addr (pv_raddr),
        .rd_data (pv_rdata)
    );

    // A page never written reads as its reset value.
    assign pm_q = pm_vld_reg ? pm_rdata
                : {1'b0, (pm_zero_reg ? ORD_MAX : ORDER_NONE)};

    always_comb
    begin
        bytes_sum = {1'b0, request_bytes} + (BYTES_W + 1)'((1 << PAGE_BYTES_LOG2) - 1);
        pages     = bytes_sum[BYTES_W:PAGE_BYTES_LOG2];
        pages_m1  = pages - PAGES_W'(1);
        req_ord   = 5'd0;
        if (pages > PAGES_W'(1))
        begin
            for (int k = 0; k < PAGES_W; k++)
            begin
                if (pages_m1[k])
                begin
                    req_ord = 5'(k + 1);
                end
            end
        end
    end

    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < NUM_ORD; i++)
        begin
            if (!found && (ORD_W'(i) >= ord_reg) && (head_reg[i] != LINK_NIL))
            begin
                found     = 1'b1;
                found_idx = ORD_W'(i);
            end
        end
    end

    always_comb
    begin
        push_page = (func_reg == FUNC_FREE) ? cur_reg
                  : pos_reg + (PAGE_W'(1) << j_reg);
        push_ord  = (func_reg == FUNC_FREE) ? ord_reg : j_reg;
        t_cur     = tail_reg[push_ord];
        buddy     = cur_reg ^ (PAGE_W'(1) << ord_reg);
        lo_page   = (cur_reg < hi_reg) ? cur_reg : hi_reg;
        hi_page   = (cur_reg < hi_reg) ? hi_reg : cur_reg;
        claim_ord = (pm_q[ORD_W-1:0] > ORD_MAX) ? ORD_MAX : pm_q[ORD_W-1:0];
        // Until page 0 is first taken it is the only member of the top list,
        // and its link memory entry has never been written.
        take_next = ((pos_reg == '0) && !pm_valid_reg[0]) ? LINK_NIL : nx_rdata;
    end

    always_comb
    begin
        stat.func       = func_reg;
        stat.zero       = zero_reg;
        stat.too_large  = large_reg;
        stat.found      = found;
        stat.range_err  = range_reg;
        stat.split_done = (j_reg == lvl_reg);
        stat.used       = pm_q[ORD_W];
        stat.ord_top    = (ord_reg == ORD_MAX);
        stat.buddy_ok   = !pm_q[ORD_W] && (pm_q[ORD_W-1:0] == ord_reg);
        stat.out_busy   = out_valid_reg && out_stall;
    end

    always_comb
    begin
        func_next  = func_reg;
        zero_next  = zero_reg;
        large_next = large_reg;
        range_next = range_reg;
        ord_next   = ord_reg;
        lvl_next   = lvl_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        hi_next    = hi_reg;
        np_next    = np_reg;
        t_next     = t_reg;

        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        block_page_next  = block_page_reg;
        block_order_next = block_order_reg;

        pm_vld_next  = pm_vld_reg;
        pm_zero_next = pm_zero_reg;

        head_we = 1'b0; head_idx = '0; head_val = LINK_NIL;
        tail_we = 1'b0; tail_idx = '0; tail_val = LINK_NIL;

        pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_re = 1'b0; pm_raddr = '0;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_re = 1'b0; nx_raddr = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_re = 1'b0; pv_raddr = '0;

        case (cmd.op)
            OP_LOAD:
            begin
                func_next  = func;
                zero_next  = (request_bytes == '0);
                large_next = (req_ord > 5'(MAX_ORDER));
                ord_next   = large_next ? '0 : req_ord[ORD_W-1:0];
                cur_next   = free_page[PAGE_W-1:0];
                range_next = free_page[PAGE_W];
            end
            OP_A_TAKE:
            begin
                pos_next = head_reg[found_idx][PAGE_W-1:0];
                lvl_next = found_idx;
                j_next   = ord_reg;
                nx_re    = 1'b1;
                nx_raddr = head_reg[found_idx][PAGE_W-1:0];
            end
            OP_PUSH:
            begin
                nx_we    = 1'b1;
                nx_waddr = push_page;
                nx_wdata = LINK_NIL;
                pv_we    = 1'b1;
                pv_waddr = push_page;
                pv_wdata = t_cur;
                if (func_reg == FUNC_ALLOC)
                begin
                    pm_we    = 1'b1;
                    pm_waddr = push_page;
                    pm_wdata = {1'b0, j_reg};
                end
                if (t_cur == LINK_NIL)
                begin
                    head_we  = 1'b1;
                    head_idx = push_ord;
                    head_val = {1'b0, push_page};
                end
                tail_we  = 1'b1;
                tail_idx = push_ord;
                tail_val = {1'b0, push_page};
                t_next   = t_cur;
                np_next  = push_page;
            end
            OP_LINK:
            begin
                if (t_reg != LINK_NIL)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = t_reg[PAGE_W-1:0];
                    nx_wdata = {1'b0, np_reg};
                end
                if (func_reg == FUNC_ALLOC)
                begin
                    j_next = j_reg + ORD_W'(1);
                end
            end
            OP_A_UNLINK:
            begin
                head_we  = 1'b1;
                head_idx = lvl_reg;
                head_val = take_next;
                if (take_next == LINK_NIL)
                begin
                    tail_we  = 1'b1;
                    tail_idx = lvl_reg;
                    tail_val = LINK_NIL;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = take_next[PAGE_W-1:0];
                    pv_wdata = LINK_NIL;
                end
                pm_we    = 1'b1;
                pm_waddr = pos_reg;
                pm_wdata = {1'b1, ord_reg};
            end
            OP_F_READ:
            begin
                pm_re        = 1'b1;
                pm_raddr     = cur_reg;
                pm_vld_next  = pm_valid_reg[cur_reg];
                pm_zero_next = (cur_reg == '0);
            end
            OP_F_CLAIM:
            begin
                ord_next = claim_ord;
                pm_we    = 1'b1;
                pm_waddr = cur_reg;
                pm_wdata = {1'b0, claim_ord};
            end
            OP_F_BREAD:
            begin
                hi_next      = buddy;
                pm_re        = 1'b1;
                pm_raddr     = buddy;
                pm_vld_next  = pm_valid_reg[buddy];
                pm_zero_next = (buddy == '0);
                nx_re        = 1'b1;
                nx_raddr     = buddy;
                pv_re        = 1'b1;
                pv_raddr     = buddy;
            end
            OP_F_UNLINK:
            begin
                if (pv_rdata == LINK_NIL)
                begin
                    head_we  = 1'b1;
                    head_idx = ord_reg;
                    head_val = nx_rdata;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata[PAGE_W-1:0];
                    nx_wdata = nx_rdata;
                end
                if (nx_rdata == LINK_NIL)
                begin
                    tail_we  = 1'b1;
                    tail_idx = ord_reg;
                    tail_val = pv_rdata;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata[PAGE_W-1:0];
                    pv_wdata = pv_rdata;
                end
                pm_we    = 1'b1;
                pm_waddr = lo_page;
                pm_wdata = {1'b0, ord_reg + ORD_W'(1)};
                cur_next = lo_page;
                hi_next  = hi_page;
            end
            OP_F_MERGE:
            begin
                pm_we    = 1'b1;
                pm_waddr = hi_reg;
                pm_wdata = {1'b0, ORDER_NONE};
                ord_next = ord_reg + ORD_W'(1);
            end
            OP_DONE:
            begin
                out_valid_next = 1'b1;
                status_next    = cmd.code;
                if (cmd.code == ST_ALLOC)
                begin
                    block_page_next  = pos_reg;
                    block_order_next = ord_reg;
                end
                else
                begin
                    block_page_next  = '0;
                    block_order_next = '0;
                end
            end
            default:
            begin
                func_next = func_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pm_valid_reg  <= '0;
            for (int i = 0; i < NUM_ORD; i++)
            begin
                head_reg[i] <= (i == MAX_ORDER) ? link_t'(0) : LINK_NIL;
                tail_reg[i] <= (i == MAX_ORDER) ? link_t'(0) : LINK_NIL;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pm_we)
            begin
                pm_valid_reg[pm_waddr] <= 1'b1;
            end
            if (head_we)
            begin
                head_reg[head_idx] <= head_val;
            end
            if (tail_we)
            begin
                tail_reg[tail_idx] <= tail_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        zero_reg        <= zero_next;
        large_reg       <= large_next;
        range_reg       <= range_next;
        ord_reg         <= ord_next;
        lvl_reg         <= lvl_next;
        j_reg           <= j_next;
        pos_reg         <= pos_next;
        cur_reg         <= cur_next;
        hi_reg          <= hi_next;
        np_reg          <= np_next;
        t_reg           <= t_next;
        pm_vld_reg      <= pm_vld_next;
        pm_zero_reg     <= pm_zero_next;
        status_reg      <= status_next;
        block_page_reg  <= block_page_next;
        block_order_reg <= block_order_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign block_page  = block_page_reg;
    assign block_order = block_order_reg;
endmodule

// ===== hdl/bpa_checker.sv =====
// Port-level checks of the buddy page allocator and their binding.
module bpa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [2:0]                  status,
    input logic [bpa_pkg::PAGE_W-1:0]  block_page,
    input logic [bpa_pkg::ORD_W-1:0]   block_order
);
    import bpa_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(block_page) && $stable(block_order))
        else $error("stalled result changed");

    // After a request transfer the block is busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // Only allocations carry a page and an order.
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_ALLOC) |-> (block_page == '0) && (block_order == '0))
        else $error("unused result fields not zero");

    // Allocated blocks are aligned to their order and within the pool.
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ALLOC) |-> (block_order <= ORD_MAX)
            && ((block_page & ((PAGE_W'(1) << block_order) - PAGE_W'(1))) == '0))
        else $error("allocated block misaligned");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .block_page  (block_page),
    .block_order (block_order)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the buddy page allocator.
`timescale 1ns / 100ps

module tb;
    import bpa_pkg::*;

    // One predicted or observed result of a request.
    typedef struct packed {
        logic [2:0] st;
        page_t      pg;
        ord_t       ord;
    } alloc_result_t;

    // Scoreboard: holds a private buddy-allocator state, predicts the result
    // of every accepted request and checks results in order.
    class alloc_scoreboard;
        int unsigned blk_ord [PAGE_COUNT];
        bit          blk_used[PAGE_COUNT];
        int unsigned nxt[PAGE_COUNT];
        int unsigned prv[PAGE_COUNT];
        int unsigned head[NUM_ORD];
        int unsigned tail[NUM_ORD];
        alloc_result_t pending[$];
        int errors;
        int checked;
        int n_status[8];

        function new();
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                blk_ord[i] = MAX_ORDER + 1;
                blk_used[i] = 0;
                nxt[i] = 0;
                prv[i] = 0;
            end
            for (int i = 0; i < NUM_ORD; i++)
            begin
                head[i] = PAGE_COUNT;
                tail[i] = PAGE_COUNT;
            end
            blk_ord[0] = MAX_ORDER;
            append(MAX_ORDER, 0);
            errors = 0;
            checked = 0;
        endfunction

        function void append(int unsigned o, int unsigned p);
            int unsigned t;
            t = tail[o];
            nxt[p] = PAGE_COUNT;
            prv[p] = t;
            if (t == PAGE_COUNT) head[o] = p;
            else nxt[t] = p;
            tail[o] = p;
        endfunction

        function void remove(int unsigned o, int unsigned p);
            int unsigned pr;
            int unsigned nx;
            pr = prv[p];
            nx = nxt[p];
            if (pr == PAGE_COUNT) head[o] = nx;
            else nxt[pr] = nx;
            if (nx == PAGE_COUNT) tail[o] = pr;
            else prv[nx] = pr;
        endfunction

        function alloc_result_t allocate(logic [31:0] nbytes);
            alloc_result_t r;
            longint unsigned npages;
            int unsigned want;
            int unsigned pos;
            r = '0;
            want = 0;
            if (nbytes == 0)
            begin
                r.st = ST_ZERO;
                return r;
            end
            npages = (longint'(nbytes) + (64'd1 << PAGE_BYTES_LOG2) - 1) >> PAGE_BYTES_LOG2;
            while (want < 40 && (64'd1 << want) < npages) want++;
            if (want > MAX_ORDER)
            begin
                r.st = ST_LARGE;
                return r;
            end
            for (int unsigned i = want; i <= MAX_ORDER; i++)
            begin
                pos = head[i];
                if (pos == PAGE_COUNT) continue;
                blk_used[pos] = 1;
                blk_ord[pos] = want;
                for (int unsigned j = want; j < i; j++)
                begin
                    blk_used[pos + (1 << j)] = 0;
                    blk_ord[pos + (1 << j)] = j;
                    append(j, pos + (1 << j));
                end
                remove(i, pos);
                r.st = ST_ALLOC;
                r.pg = pos;
                r.ord = want;
                return r;
            end
            r.st = ST_NOBLOCK;
            return r;
        endfunction

        function alloc_result_t release_block(int unsigned p);
            alloc_result_t r;
            int unsigned cur;
            int unsigned o;
            int unsigned bud;
            r = '0;
            if (p >= PAGE_COUNT)
            begin
                r.st = ST_RANGE;
                return r;
            end
            cur = p;
            if (!blk_used[cur])
            begin
                r.st = ST_FREE;
                return r;
            end
            blk_used[cur] = 0;
            o = blk_ord[cur];
            if (o > MAX_ORDER)
            begin
                o = MAX_ORDER;
                blk_ord[cur] = o;
            end
            while (o < MAX_ORDER)
            begin
                bud = cur ^ (1 << o);
                if (blk_used[bud] || blk_ord[bud] != o) break;
                remove(o, bud);
                if (bud < cur) cur = bud;
                blk_ord[cur] = o + 1;
                blk_ord[cur ^ (1 << o)] = MAX_ORDER + 1;
                o++;
            end
            append(o, cur);
            r.st = ST_FREED;
            return r;
        endfunction

        // Notes an accepted request and queues its predicted result.
        function void note_request(logic f, logic [31:0] nbytes, link_t pg);
            if (f == FUNC_ALLOC) pending.push_back(allocate(nbytes));
            else pending.push_back(release_block(pg));
        endfunction

        // Checks one accepted result against the oldest prediction.
        task check_result(alloc_result_t got);
            alloc_result_t want;
            checked++;
            n_status[got.st]++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no request outstanding", 0, got.st);
                return;
            end
            want = pending.pop_front();
            if (got.st !== want.st) report_mismatch("status", want.st, got.st);
            if (got.pg !== want.pg) report_mismatch("block_page", want.pg, got.pg);
            if (got.ord !== want.ord) report_mismatch("block_order", want.ord, got.ord);
        endtask

        task report_mismatch(string what, int want, int got);
            errors++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [31:0] request_bytes;
    link_t       free_page;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    page_t       block_page;
    ord_t        block_order;

    alloc_scoreboard sb;
    int idle_cycles;
    bit stim_done;
    page_t held[$];    // pages of blocks this testbench currently owns
    int n_sent;

    buddy_page_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .request_bytes(request_bytes),
        .free_page    (free_page),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_page   (block_page),
        .block_order  (block_order)
    );

    always #1 clk = ~clk;

    // Sends one request: after a random gap with valid low and noise on the
    // fields, holds the transfer until the block accepts it. The prediction
    // is made at the accepting edge. Valid stays high after the transfer so
    // that a request with no gap follows directly; idle_input drops it.
    task automatic send_request(logic f, logic [31:0] nbytes, link_t pg);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            func <= $urandom_range(0, 1);
            request_bytes <= $urandom;
            free_page <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        request_bytes <= nbytes;
        free_page <= pg;
        do @(posedge clk); while (in_stall);
        sb.note_request(f, nbytes, pg);
        n_sent++;
    endtask

    // Takes the input channel idle right after a transfer.
    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    // Allocates a request of nbytes bytes; the free_page field carries noise.
    task automatic do_alloc(logic [31:0] nbytes);
        send_request(FUNC_ALLOC, nbytes, $urandom);
    endtask

    task automatic do_free(link_t pg);
        send_request(FUNC_FREE, $urandom, pg);
    endtask

    // Results are taken at the edge; owned pages are recorded so that later
    // frees hit real blocks. Random stalls are drawn per result.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result('{status, block_page, block_order});
                if (status == ST_ALLOC) held.push_back(block_page);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: a free with full merging plus a full receiver stall ends well
    // before this limit on cycles without a transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random size for an allocation: mostly small orders, a few large.
    function automatic logic [31:0] rand_size();
        int o;
        logic [31:0] base;
        o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ORDER) : $urandom_range(0, 3);
        base = (32'd1 << (o + PAGE_BYTES_LOG2));
        // Anything from just above half the order up to the full order.
        return $urandom_range(base, (base >> 1) + 1);
    endfunction

    initial
    begin
        int idx;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        request_bytes = '0;
        free_page = '0;
        out_stall = 1'b0;
        idle_cycles = 0;
        n_sent = 0;
        stim_done = 0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, every status and whole-pool cases.
        do_alloc(32'd0);                       // zero size
        do_alloc(32'hFFFF_FFFF);               // far too large
        do_alloc(32'h0010_0001);               // just over the pool
        do_alloc(32'h0010_0000);               // whole pool
        do_alloc(32'd1);                       // pool exhausted
        do_free(9'd511);                       // out of range
        do_free(9'd256);                       // first page out of range
        do_free(9'd1);                         // inside a used block
        do_free(9'd0);                         // whole pool back, no merge
        do_free(9'd0);                         // already free
        do_alloc(32'd1);                       // one page, full split chain
        do_alloc(32'd4096);
        do_alloc(32'd4097);                    // two pages
        do_alloc(32'h0008_0000);               // half pool
        do_free(9'd255);                       // free page, never allocated
        do_free(9'd0);
        do_free(9'd1);
        do_free(9'd2);                         // merges cascade to order 7
        do_free(9'd128);
        do_alloc(32'h7FFF_FFFF);
        do_alloc(32'h8000_0000);
        held.delete();

        // Random part: well-formed alloc/free traffic with some noise.
        while (n_sent < 1350)
        begin
            case ($urandom_range(0, 19))
                0: do_free($urandom);                      // noise, any page
                1: do_alloc($urandom);                     // noise, any size
                2: do_alloc($urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF);
                3, 4, 5, 6, 7, 8, 9, 10:
                begin
                    if (held.size() > 0)
                    begin
                        idx = $urandom_range(0, held.size() - 1);
                        do_free(held[idx]);
                        held.delete(idx);
                    end
                    else
                        do_alloc(rand_size());
                end
                default: do_alloc(rand_size());
            endcase
            // Occasionally drain everything to get back to the whole pool.
            if ($urandom_range(0, 199) == 0)
            begin
                idle_input();
                while (sb.pending.size() != 0) @(posedge clk);
                while (held.size() > 0) do_free(held.pop_front());
            end
        end
        idle_input();
        stim_done = 1;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d requests, checked %0d results.", n_sent, sb.checked);
        $display("Status counts: alloc %0d, freed %0d, zero %0d, large %0d,",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
                 " none %0d, range %0d, dup %0d",
                 sb.n_status[4], sb.n_status[5], sb.n_status[6]);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
